/* design/tte_pkg.sv */
// Shared constants and types for the tap tempo estimator.
`timescale 1ns / 1ps

package tte_pkg;

  localparam int WINDOW_TAPS = 4;
  localparam int TIME_BITS   = 32;
  localparam int TAP_W       = 32;
  localparam int TEMPO_W     = 16;
  localparam int USED_W      = 3;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 2;

  localparam int CNT_W       = $clog2(WINDOW_TAPS + 1);
  localparam int WIN_IDX_W   = $clog2(WINDOW_TAPS);

  // Wide enough for 600000000 * (WINDOW_TAPS - 1) and for any span.
  localparam int DIV_W       = (TIME_BITS > 34) ? TIME_BITS : 34;
  localparam int DIV_CNT_W   = $clog2(DIV_W);

  localparam logic [DIV_W-1:0] TENTHS_PER_MIN_US = DIV_W'(600000000);

  localparam logic [CFG_IDX_W-1:0] REG_TAP_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TEMPO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMPO   = 2'd2;

  localparam logic [TIME_BITS-1:0] TIMEOUT_RESET = TIME_BITS'(2000000);
  localparam logic [TEMPO_W-1:0]   MIN_RESET     = TEMPO_W'(200);
  localparam logic [TEMPO_W-1:0]   MAX_RESET     = TEMPO_W'(3000);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } tte_state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } tte_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } tte_div_rsp_t;

endpackage

/* design/tte_div.sv */
// Restoring serial divider: one quotient bit per cycle through a shared subtractor.
`timescale 1ns / 1ps

module tte_div
  import tte_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  tte_div_req_t req,
  output tte_div_rsp_t rsp
);

  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DIV_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DIV_W:0]       shifted;
  logic [DIV_W:0]       diff;
  logic                 ge;

  always_comb begin
    shifted = {rem_r, quo_r[DIV_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    ge      = (shifted >= {1'b0, dvs_r});
    // The partial remainder stays below the divisor, so DIV_W bits hold it.
    rem_nxt = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
    quo_nxt = {quo_r[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

/* design/tap_tempo_estimator_core.sv */
// Tap tempo estimator top level: tap window, sequencer, clamp and output register.
//
//  Channel  Direction  Handshake                  Payload
//  in_      slave      in_tvalid / in_tready      tap_time_us
//  out_     master     out_tvalid / out_tready    tempo_tenths, taps_used
//  cfg_     write      cfg_we                     cfg_index, cfg_wdata
//
// A tap that yields no result leaves in_ ready for the next tap. A tap that yields a
// result goes through the serial divider, which retires one quotient bit per cycle;
// a zero span skips the divider and goes straight to the output register.
// Reset is synchronous and active low; it empties the window and restores the
// register defaults. The result sits in an output register, so a stalled out_
// side holds the block only once a second result is ready to be written.
`timescale 1ns / 1ps

module tap_tempo_estimator_core
  import tte_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,    // [31:0] tap_time_us
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,   // [15:0] tempo_tenths, [18:16] taps_used
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  tte_state_t state_r, state_nxt;

  logic [TIME_BITS-1:0] timeout_r;
  logic [TEMPO_W-1:0]   min_r;
  logic [TEMPO_W-1:0]   max_r;

  logic [TIME_BITS-1:0] win_r [WINDOW_TAPS];
  logic [TIME_BITS-1:0] last_r;
  logic [CNT_W-1:0]     held_r, held_nxt;
  logic                 zero_span_r;
  logic [USED_W-1:0]    used_r;

  logic                 out_tvalid_r;
  logic [TEMPO_W-1:0]   out_tempo_r;
  logic [USED_W-1:0]    out_used_r;

  logic                 accept;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] gap;
  logic                 drop;
  logic                 full;
  logic [TIME_BITS-1:0] oldest;
  logic [TIME_BITS-1:0] span;
  logic                 want_result;
  logic [CNT_W-1:0]     n_minus1;
  logic [DIV_W-1:0]     numerator;
  logic                 out_free;
  logic [TEMPO_W-1:0]   tempo;

  tte_div_req_t div_req;
  tte_div_rsp_t div_rsp;

  tte_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign now       = TIME_BITS'(in_tdata);

  always_comb begin
    gap  = now - last_r;
    drop = (held_r == '0) || (gap > timeout_r);
    full = (held_r == CNT_W'(WINDOW_TAPS));
    if (drop) begin
      held_nxt = CNT_W'(1);
      oldest   = now;
    end else if (full) begin
      held_nxt = held_r;
      oldest   = win_r[1];
    end else begin
      held_nxt = held_r + CNT_W'(1);
      oldest   = win_r[0];
    end
    span        = now - oldest;
    want_result = (held_nxt >= CNT_W'(2));
    n_minus1    = held_nxt - CNT_W'(1);
    numerator   = DIV_W'(TENTHS_PER_MIN_US * n_minus1);
  end

  always_comb begin
    div_req.start    = accept && want_result && (span != '0);
    div_req.dividend = numerator;
    div_req.divisor  = DIV_W'(span);
  end

  // Clamp: if the limits cross, a quotient under min_r gives min_r, else max_r.
  always_comb begin
    if (zero_span_r) begin
      tempo = max_r;
    end else if (div_rsp.quotient < DIV_W'(min_r)) begin
      tempo = min_r;
    end else if (div_rsp.quotient > DIV_W'(max_r)) begin
      tempo = max_r;
    end else begin
      tempo = div_rsp.quotient[TEMPO_W-1:0];
    end
  end

  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && want_result) begin
          state_nxt = (span == '0) ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      min_r     <= MIN_RESET;
      max_r     <= MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TAP_TIMEOUT: timeout_r <= TIME_BITS'(cfg_wdata);
        REG_MIN_TEMPO:   min_r     <= cfg_wdata[TEMPO_W-1:0];
        REG_MAX_TEMPO:   max_r     <= cfg_wdata[TEMPO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (accept) begin
      held_r <= held_nxt;
    end
  end

  // Window payload: the oldest tap always sits in entry zero.
  always_ff @(posedge clk) begin
    if (accept) begin
      last_r      <= now;
      zero_span_r <= (span == '0);
      used_r      <= USED_W'(held_nxt);
      if (drop) begin
        win_r[0] <= now;
      end else if (full) begin
        for (int i = 0; i < WINDOW_TAPS - 1; i++) begin
          win_r[i] <= win_r[i+1];
        end
        win_r[WINDOW_TAPS-1] <= now;
      end else begin
        win_r[held_r[WIN_IDX_W-1:0]] <= now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_tempo_r <= tempo;
      out_used_r  <= used_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'b0, out_used_r, out_tempo_r};

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_rsp.busy)
    else $error("divider busy while accepting taps");

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_W'(WINDOW_TAPS))
    else $error("tap count beyond window size");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("divider finished outside of a division");

  a_result_taps: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_used_r >= USED_W'(2)))
    else $error("result beat with fewer than two taps");

  a_busy_after_tap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && want_result) |=> !in_tready)
    else $error("ready again right after a tap that needs a result");

endmodule
